[design/packed_junk_stream_unpacker_core_defines.svh]
// Assertion macros used by the unpacker controller.
`ifndef PACKED_JUNK_STREAM_UNPACKER_CORE_DEFINES_SVH
`define PACKED_JUNK_STREAM_UNPACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PJSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PJSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pjsu_pkg.sv]
package pjsu_pkg;

    // Generator geometry.
    localparam int unsigned GEN_K       = 521;
    localparam int unsigned GEN_J       = 32;
    localparam int unsigned SEED_WORDS  = 17;
    localparam int unsigned SEED_BYTES  = 68;
    localparam int unsigned EXP_SHL     = 23;
    localparam int unsigned EXP_SHR     = 9;
    localparam int unsigned ADDR_W      = $clog2(GEN_K + 1);

    // Chunk length limit and field width.
    localparam int unsigned MAX_CHUNK_BYTES = 2097152;
    localparam int unsigned LEN_W           = 22;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STREAM = 2'd1,
        OP_PULL   = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        RD_X17,
        RD_X16,
        RD_ELEM,
        RD_OTHER,
        RD_GIDX
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        rd_sel_t rd_sel;
        logic    load_a;
        logic    wr_expand;
        logic    wr_adv;
        logic    elem_clr;
        logic    elem_inc;
        logic    pull_emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic xpand_req;
        logic pull_req;
        logic pull_wrap;
        logic elem_last;
        logic out_busy;
    } status_t;

endpackage

[design/pjsu_datapath.sv]
module pjsu_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [1:0]        operation,
    input  logic [7:0]        stream_byte,
    input  logic [21:0]       chunk_length,
    input  logic              out_taken,
    input  pjsu_pkg::cmd_t    cmd,
    output pjsu_pkg::status_t status,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_LITERAL, PH_SEED, PH_JUNK, PH_DONE
    } phase_t;

    localparam logic [pjsu_pkg::ADDR_W-1:0] K_A    = pjsu_pkg::ADDR_W'(pjsu_pkg::GEN_K);
    localparam logic [pjsu_pkg::ADDR_W-1:0] LAST_A = pjsu_pkg::ADDR_W'(pjsu_pkg::GEN_K - 1);
    localparam logic [pjsu_pkg::ADDR_W-1:0] J_A    = pjsu_pkg::ADDR_W'(pjsu_pkg::GEN_J);
    localparam logic [pjsu_pkg::ADDR_W-1:0] WRAP_A =
        pjsu_pkg::ADDR_W'(pjsu_pkg::GEN_K - pjsu_pkg::GEN_J);
    localparam logic [pjsu_pkg::ADDR_W-1:0] SW_A   = pjsu_pkg::ADDR_W'(pjsu_pkg::SEED_WORDS);
    localparam logic [pjsu_pkg::LEN_W-1:0]  MAX_L  =
        pjsu_pkg::LEN_W'(pjsu_pkg::MAX_CHUNK_BYTES);

    logic [31:0] mem [pjsu_pkg::GEN_K];
    logic [31:0] rdata_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] hs_reg, hs_next;
    logic [1:0]  hbc_reg, hbc_next;
    logic [30:0] segrem_reg, segrem_next;
    logic [6:0]  seedcnt_reg, seedcnt_next;
    logic [31:0] sw_reg, sw_next;
    logic [pjsu_pkg::LEN_W-1:0] bp_reg, bp_next, target_reg, target_next;
    logic [pjsu_pkg::ADDR_W-1:0] gidx_reg, gidx_next, elem_reg, elem_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] a_reg, a_next, p_reg, p_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic [pjsu_pkg::LEN_W-1:0] len_c;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        seed_wr;
    logic        xpand_req, pull_req, pull_wrap;
    logic [31:0] xnew;
    logic [pjsu_pkg::ADDR_W-1:0] rd_addr, wr_addr, other_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    // Expansion word and the partner of a word in one advance pass.
    assign xnew = (a_reg << pjsu_pkg::EXP_SHL) ^ (rdata_reg >> pjsu_pkg::EXP_SHR) ^ p_reg;
    assign other_addr = (elem_reg < J_A) ? (elem_reg + WRAP_A) : (elem_reg - J_A);

    // Read address selection.
    always_comb
    begin
        case (cmd.rd_sel)
            pjsu_pkg::RD_X17:   rd_addr = elem_reg - SW_A;
            pjsu_pkg::RD_X16:   rd_addr = elem_reg - (SW_A - 1'b1);
            pjsu_pkg::RD_ELEM:  rd_addr = elem_reg;
            pjsu_pkg::RD_OTHER: rd_addr = other_addr;
            default:            rd_addr = gidx_reg;
        endcase
    end

    // Write port selection.
    always_comb
    begin
        wr_en = seed_wr | cmd.wr_expand | cmd.wr_adv;
        if (seed_wr)
        begin
            wr_addr = pjsu_pkg::ADDR_W'(seedcnt_reg[6:2]);
            wr_data = sw_next;
        end
        else if (cmd.wr_expand)
        begin
            wr_addr = elem_reg;
            wr_data = xnew;
        end
        else
        begin
            wr_addr = elem_reg;
            wr_data = a_reg ^ rdata_reg;
        end
    end

    // Generator word store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // Item parsing, byte emission and generator bookkeeping.
    always_comb
    begin
        phase_next     = phase_reg;
        hs_next        = hs_reg;
        hbc_next       = hbc_reg;
        segrem_next    = segrem_reg;
        seedcnt_next   = seedcnt_reg;
        sw_next        = sw_reg;
        bp_next        = bp_reg;
        target_next    = target_reg;
        gidx_next      = gidx_reg;
        biw_next       = biw_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        elem_next      = elem_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg & ~out_taken;
        len_c          = (chunk_length > MAX_L) ? MAX_L : chunk_length;
        emit           = 1'b0;
        emit_byte      = stream_byte;
        seed_wr        = 1'b0;
        xpand_req      = 1'b0;
        pull_req       = 1'b0;
        pull_wrap      = 1'b0;

        if (in_fire)
        begin
            case (pjsu_pkg::op_t'(operation))
                pjsu_pkg::OP_START:
                begin
                    target_next  = len_c;
                    bp_next      = '0;
                    hs_next      = '0;
                    hbc_next     = '0;
                    segrem_next  = '0;
                    seedcnt_next = '0;
                    gidx_next    = '0;
                    biw_next     = '0;
                    phase_next   = (len_c == '0) ? PH_DONE : PH_HEADER;
                end
                pjsu_pkg::OP_STREAM:
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            hs_next = {hs_reg[23:0], stream_byte};
                            if (hbc_reg != 2'd3)
                                hbc_next = hbc_reg + 2'd1;
                            else
                            begin
                                hbc_next    = '0;
                                segrem_next = hs_next[30:0];
                                if (hs_next[31])
                                begin
                                    seedcnt_next = '0;
                                    phase_next   = PH_SEED;
                                end
                                else if (hs_next[30:0] != '0)
                                    phase_next = PH_LITERAL;
                            end
                        end
                        PH_LITERAL:
                            emit = 1'b1;
                        PH_SEED:
                        begin
                            sw_next      = {sw_reg[23:0], stream_byte};
                            seed_wr      = (seedcnt_reg[1:0] == 2'd3);
                            seedcnt_next = seedcnt_reg + 7'd1;
                            if (seed_wr)
                                p_next = sw_next;
                            if (seedcnt_reg == 7'(pjsu_pkg::SEED_BYTES - 1))
                            begin
                                seedcnt_next = '0;
                                gidx_next    = '0;
                                biw_next     = '0;
                                xpand_req    = 1'b1;
                                phase_next   = (segrem_reg == '0) ? PH_HEADER : PH_JUNK;
                            end
                        end
                        default:
                            ;
                    endcase
                end
                pjsu_pkg::OP_PULL:
                begin
                    if (phase_reg == PH_JUNK)
                    begin
                        pull_req = 1'b1;
                        if (gidx_reg == K_A)
                        begin
                            pull_wrap = 1'b1;
                            gidx_next = '0;
                        end
                    end
                end
                default:
                    ;
            endcase
        end

        // Operand capture and expansion carry word.
        if (cmd.load_a)
            a_next = rdata_reg;
        if (cmd.wr_expand)
            p_next = xnew;

        // Element counter for expansion and advance passes.
        if (xpand_req)
            elem_next = SW_A;
        else if (cmd.elem_clr)
            elem_next = '0;
        else if (cmd.elem_inc)
            elem_next = elem_reg + 1'b1;

        // Generator byte, most significant first.
        if (cmd.pull_emit)
        begin
            emit = 1'b1;
            case (biw_reg)
                2'd0:    emit_byte = rdata_reg[31:24];
                2'd1:    emit_byte = rdata_reg[23:16];
                2'd2:    emit_byte = rdata_reg[15:8];
                default: emit_byte = rdata_reg[7:0];
            endcase
            biw_next = biw_reg + 2'd1;
            if (biw_reg == 2'd3)
                gidx_next = gidx_reg + 1'b1;
        end

        // Count the byte and load the output register.
        if (emit)
        begin
            bp_next        = bp_reg + 1'b1;
            segrem_next    = segrem_reg - 31'd1;
            out_byte_next  = emit_byte;
            out_valid_next = 1'b1;
            out_last_next  = (bp_next >= target_reg);
            if (bp_next >= target_reg)
                phase_next = PH_DONE;
            else if (segrem_next == '0)
                phase_next = PH_HEADER;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hbc_reg       <= '0;
            segrem_reg    <= '0;
            seedcnt_reg   <= '0;
            bp_reg        <= '0;
            target_reg    <= '0;
            gidx_reg      <= '0;
            biw_reg       <= '0;
            elem_reg      <= '0;
            out_valid_reg <= 1'b0;
            hs_reg        <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hbc_reg       <= hbc_next;
            segrem_reg    <= segrem_next;
            seedcnt_reg   <= seedcnt_next;
            bp_reg        <= bp_next;
            target_reg    <= target_next;
            gidx_reg      <= gidx_next;
            biw_reg       <= biw_next;
            elem_reg      <= elem_next;
            out_valid_reg <= out_valid_next;
            hs_reg        <= hs_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sw_reg       <= sw_next;
        a_reg        <= a_next;
        p_reg        <= p_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign status.xpand_req = xpand_req;
    assign status.pull_req  = pull_req;
    assign status.pull_wrap = pull_wrap;
    assign status.elem_last = (elem_reg == LAST_A);
    assign status.out_busy  = out_valid_reg & ~out_taken;
    assign out_valid        = out_valid_reg;
    assign out_byte         = out_byte_reg;
    assign out_last         = out_last_reg;

endmodule

[design/pjsu_ctrl.sv]
`include "packed_junk_stream_unpacker_core_defines.svh"

module pjsu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  pjsu_pkg::status_t status,
    output pjsu_pkg::cmd_t    cmd,
    output logic              in_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_XA, S_XB, S_XC, S_AA, S_AB, S_AC, S_PA, S_PB
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] adv_left_reg, adv_left_next;
    logic       pend_reg, pend_next;

    // Sequencer for expansion, advance passes and junk reads.
    always_comb
    begin
        state_next    = state_reg;
        adv_left_next = adv_left_reg;
        pend_next     = pend_reg;
        cmd           = '0;
        cmd.rd_sel    = pjsu_pkg::RD_GIDX;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.xpand_req)
                    state_next = S_XA;
                else if (status.pull_req)
                begin
                    if (status.pull_wrap)
                    begin
                        state_next    = S_AA;
                        adv_left_next = 2'd0;
                        pend_next     = 1'b1;
                    end
                    else
                        state_next = S_PA;
                end
            end
            S_XA:
            begin
                cmd.rd_sel = pjsu_pkg::RD_X17;
                state_next = S_XB;
            end
            S_XB:
            begin
                cmd.rd_sel = pjsu_pkg::RD_X16;
                cmd.load_a = 1'b1;
                state_next = S_XC;
            end
            S_XC:
            begin
                cmd.wr_expand = 1'b1;
                if (status.elem_last)
                begin
                    cmd.elem_clr  = 1'b1;
                    adv_left_next = 2'd3;
                    pend_next     = 1'b0;
                    state_next    = S_AA;
                end
                else
                begin
                    cmd.elem_inc = 1'b1;
                    state_next   = S_XA;
                end
            end
            S_AA:
            begin
                cmd.rd_sel = pjsu_pkg::RD_ELEM;
                state_next = S_AB;
            end
            S_AB:
            begin
                cmd.rd_sel = pjsu_pkg::RD_OTHER;
                cmd.load_a = 1'b1;
                state_next = S_AC;
            end
            S_AC:
            begin
                cmd.wr_adv = 1'b1;
                if (status.elem_last)
                begin
                    cmd.elem_clr = 1'b1;
                    if (adv_left_reg == 2'd0)
                        state_next = pend_reg ? S_PA : S_IDLE;
                    else
                    begin
                        adv_left_next = adv_left_reg - 2'd1;
                        state_next    = S_AA;
                    end
                end
                else
                begin
                    cmd.elem_inc = 1'b1;
                    state_next   = S_AA;
                end
            end
            S_PA:
            begin
                cmd.rd_sel = pjsu_pkg::RD_GIDX;
                pend_next  = 1'b0;
                state_next = S_PB;
            end
            S_PB:
            begin
                cmd.pull_emit = 1'b1;
                state_next    = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and pass bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            adv_left_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            adv_left_reg <= adv_left_next;
            pend_reg     <= pend_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE) && !status.out_busy;

    `PJSU_ASSERT_SAME(a_one_writer, 1'b1, $onehot0({cmd.wr_expand, cmd.wr_adv}), "two writers")
    `PJSU_ASSERT_NEXT(a_seed_expands, (state_reg == S_IDLE) && status.xpand_req, state_reg == S_XA, "expansion did not start")
    `PJSU_ASSERT_NEXT(a_wrap_advances, (state_reg == S_IDLE) && !status.xpand_req && status.pull_req && status.pull_wrap, (state_reg == S_AA) && pend_reg, "wrap did not advance")
    `PJSU_ASSERT_SAME(a_busy_not_ready, state_reg != S_IDLE, !in_ready, "ready while busy")

endmodule

[design/packed_junk_stream_unpacker_core.sv]
// Packed junk stream unpacker. A start transaction (tuser 0) sets the chunk length
// and clears the parser; stream-byte transactions (tuser 1) carry segment headers,
// literal bytes and 68-byte junk seeds; pull transactions (tuser 2) each return one
// generator byte, read as a word from the 521-word generator store. Every 521 words
// of junk, a pull first runs one generator advance. The last seed byte starts the
// expansion of the remaining 504 words and four generator advances, during which no
// transaction is accepted. Output stops at the chunk length, flagged by tlast; input
// after that is ignored until the next start.
module packed_junk_stream_unpacker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [7:0] stream_byte, [29:8] chunk_length, [31:30] zero
    input  logic [1:0]  s_tuser,  // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] out_byte
    output logic        m_tlast
);

    pjsu_pkg::cmd_t    cmd;
    pjsu_pkg::status_t status;
    logic              in_fire;

    assign in_fire = s_tvalid && s_tready;

    pjsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    pjsu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .operation    (s_tuser),
        .stream_byte  (s_tdata[7:0]),
        .chunk_length (s_tdata[29:8]),
        .out_taken    (m_tvalid && m_tready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_byte     (m_tdata),
        .out_last     (m_tlast)
    );

endmodule

[dv/testbench.sv]
module testbench;

    typedef struct {
        pjsu_pkg::op_t op;
        logic [7:0]    data;
        logic [21:0]   len;
    } stream_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } chunk_byte_t;

    localparam int PH_IDLE    = 0;
    localparam int PH_HEADER  = 1;
    localparam int PH_LITERAL = 2;
    localparam int PH_SEED    = 3;
    localparam int PH_JUNK    = 4;
    localparam int PH_DONE    = 5;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 8000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // [7:0] stream_byte, [29:8] chunk_length, [31:30] zero
    logic [1:0]  s_tuser;  // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;  // [7:0] out_byte
    logic        m_tlast;

    packed_junk_stream_unpacker_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predicted block state.
    logic [31:0] gen_words [pjsu_pkg::GEN_K];
    int unsigned gen_index;
    int unsigned gen_byte;
    int          phase;
    logic [31:0] hdr_shift;
    int unsigned hdr_count;
    logic [30:0] seg_left;
    int unsigned seed_count;
    logic [21:0] produced;
    logic [21:0] target;

    stream_item_t pending_items[$];
    chunk_byte_t  expected_bytes[$];
    stream_item_t cur_item;
    int           errors = 0;
    int           accepted = 0;
    int           checked = 0;
    int           chunks = 0;
    int           junk_segments = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int unsigned  cycle_count = 0;

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // One step of the xor lagged Fibonacci generator.
    function automatic void gen_advance();
        for (int i = 0; i < pjsu_pkg::GEN_J; i++)
            gen_words[i] ^= gen_words[i + pjsu_pkg::GEN_K - pjsu_pkg::GEN_J];
        for (int i = pjsu_pkg::GEN_J; i < pjsu_pkg::GEN_K; i++)
            gen_words[i] ^= gen_words[i - pjsu_pkg::GEN_J];
    endfunction

    function automatic void gen_expand();
        for (int i = pjsu_pkg::SEED_WORDS; i < pjsu_pkg::GEN_K; i++)
            gen_words[i] = (gen_words[i - 17] << pjsu_pkg::EXP_SHL)
                           ^ (gen_words[i - 16] >> pjsu_pkg::EXP_SHR)
                           ^ gen_words[i - 1];
        for (int i = 0; i < 4; i++)
            gen_advance();
        gen_index = 0;
        gen_byte = 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        chunk_byte_t r;
        produced++;
        seg_left = seg_left - 31'd1;
        r.data = b;
        if (produced >= target)
        begin
            r.last = 1'b1;
            phase = PH_DONE;
        end
        else
        begin
            r.last = 1'b0;
            if (seg_left == 0)
                phase = PH_HEADER;
        end
        expected_bytes.push_back(r);
    endfunction

    // Update the predicted state for one accepted transaction.
    function automatic void predict_chunk(stream_item_t it);
        int unsigned w;
        logic [31:0] word;
        case (it.op)
            pjsu_pkg::OP_START:
            begin
                target = (it.len > pjsu_pkg::MAX_CHUNK_BYTES) ?
                         pjsu_pkg::LEN_W'(pjsu_pkg::MAX_CHUNK_BYTES) : it.len;
                produced = 0;
                hdr_shift = 0;
                hdr_count = 0;
                seg_left = 0;
                seed_count = 0;
                gen_index = 0;
                gen_byte = 0;
                phase = (target == 0) ? PH_DONE : PH_HEADER;
            end
            pjsu_pkg::OP_STREAM:
            begin
                if (phase == PH_HEADER)
                begin
                    hdr_shift = {hdr_shift[23:0], it.data};
                    if (hdr_count < 3)
                    begin
                        hdr_count++;
                    end
                    else
                    begin
                        hdr_count = 0;
                        seg_left = hdr_shift[30:0];
                        if (hdr_shift[31])
                        begin
                            seed_count = 0;
                            phase = PH_SEED;
                        end
                        else if (seg_left != 0)
                        begin
                            phase = PH_LITERAL;
                        end
                    end
                end
                else if (phase == PH_LITERAL)
                begin
                    emit_byte(it.data);
                end
                else if (phase == PH_SEED)
                begin
                    w = (seed_count >> 2) % pjsu_pkg::SEED_WORDS;
                    if ((seed_count & 3) == 0)
                        gen_words[w] = {24'd0, it.data};
                    else
                        gen_words[w] = {gen_words[w][23:0], it.data};
                    seed_count++;
                    if (seed_count >= pjsu_pkg::SEED_BYTES)
                    begin
                        seed_count = 0;
                        gen_expand();
                        phase = (seg_left == 0) ? PH_HEADER : PH_JUNK;
                    end
                end
            end
            pjsu_pkg::OP_PULL:
            begin
                if (phase == PH_JUNK)
                begin
                    if (gen_index >= pjsu_pkg::GEN_K)
                    begin
                        gen_advance();
                        gen_index = 0;
                    end
                    word = gen_words[gen_index];
                    emit_byte(word[31 - 8 * gen_byte -: 8]);
                    gen_byte = (gen_byte + 1) & 3;
                    if (gen_byte == 0)
                        gen_index++;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Stimulus helpers.
    task automatic push_item(pjsu_pkg::op_t op, logic [7:0] data, logic [21:0] len);
        stream_item_t it;
        it.op = op;
        it.data = data;
        it.len = len;
        pending_items.push_back(it);
    endtask

    task automatic push_header(logic junk, logic [30:0] size);
        logic [31:0] h;
        h = {junk, size};
        for (int i = 3; i >= 0; i--)
            push_item(pjsu_pkg::OP_STREAM, h[8 * i +: 8], 22'($urandom));
    endtask

    task automatic push_run(pjsu_pkg::op_t op, int n);
        for (int i = 0; i < n; i++)
            push_item(op, 8'($urandom), 22'($urandom));
    endtask

    task automatic push_junk(logic [30:0] size, int pulls);
        push_header(1'b1, size);
        push_run(pjsu_pkg::OP_STREAM, pjsu_pkg::SEED_BYTES);
        push_run(pjsu_pkg::OP_PULL, pulls);
        junk_segments++;
    endtask

    // Sender: bursts of random length with random gaps; predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= pjsu_pkg::OP_RSVD;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (s_tvalid && s_tready)
            begin
                predict_chunk(cur_item);
                accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_item.len, cur_item.data};
                    s_tuser  <= cur_item.op;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: always ready, random, or a fixed duty cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            case ((cycle_count >> 8) % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom);
                default: m_tready <= (cycle_count % 7) < 3;
            endcase
        end
    end

    // Check each output transaction against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output byte %02h last %0b", $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                if (m_tdata !== expected_bytes[0].data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             expected_bytes[0].data, m_tdata);
                    errors++;
                end
                if (m_tlast !== expected_bytes[0].last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             expected_bytes[0].last, m_tlast);
                    errors++;
                end
                void'(expected_bytes.pop_front());
                checked++;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("packed_junk_stream_unpacker_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int          seg;
        int          sz;
        logic [21:0] clen;
        rst_n = 1'b0;
        for (int i = 0; i < pjsu_pkg::GEN_K; i++)
            gen_words[i] = '0;
        gen_index = 0;
        gen_byte = 0;
        phase = PH_IDLE;
        hdr_shift = 0;
        hdr_count = 0;
        seg_left = 0;
        seed_count = 0;
        produced = 0;
        target = 0;

        // Directed: ignored items, zero and clamped lengths, empty and cut segments.
        push_item(pjsu_pkg::OP_RSVD, 8'hff, 22'h3fffff);
        push_item(pjsu_pkg::OP_STREAM, 8'h5a, 22'd0);
        push_item(pjsu_pkg::OP_PULL, 8'h00, 22'd0);
        push_item(pjsu_pkg::OP_START, 8'h00, 22'd0);
        push_item(pjsu_pkg::OP_STREAM, 8'h00, 22'd0);
        push_item(pjsu_pkg::OP_START, 8'h00, 22'h3fffff);
        push_item(pjsu_pkg::OP_PULL, 8'h00, 22'd0);
        push_header(1'b0, 31'd0);
        push_header(1'b0, 31'd2);
        push_item(pjsu_pkg::OP_STREAM, 8'h00, 22'd0);
        push_item(pjsu_pkg::OP_STREAM, 8'hff, 22'd0);
        push_item(pjsu_pkg::OP_START, 8'h00, 22'd2);
        push_header(1'b0, 31'h7fffffff);
        push_run(pjsu_pkg::OP_STREAM, 4);
        chunks = 3;

        // Random: one junk segment spanning many generator words, then mixed chunks.
        push_item(pjsu_pkg::OP_START, 8'($urandom), 22'd3000);
        push_junk(31'd90, 90);
        push_item(pjsu_pkg::OP_STREAM, 8'($urandom), 22'($urandom));
        push_header(1'b0, 31'd1);
        push_run(pjsu_pkg::OP_STREAM, 1);
        chunks++;
        while (pending_items.size() < 400)
        begin
            if ($urandom_range(0, 3) == 0)
                clen = 22'($urandom);
            else
                clen = 22'($urandom_range(1, 60));
            push_item(pjsu_pkg::OP_START, 8'($urandom), clen);
            chunks++;
            for (seg = $urandom_range(1, 4); seg > 0; seg--)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        sz = $urandom_range(0, 12);
                        push_header(1'b0, 31'(sz));
                        push_run(pjsu_pkg::OP_STREAM, sz);
                    end
                    4:
                    begin
                        push_header(1'b0, 31'($urandom));
                        push_run(pjsu_pkg::OP_STREAM, $urandom_range(0, 10));
                    end
                    5, 6:
                    begin
                        sz = $urandom_range(0, 23);
                        push_junk(31'(sz), sz);
                    end
                    7:
                    begin
                        push_junk(31'($urandom), $urandom_range(0, 12));
                    end
                    default:
                    begin
                        // Noise: misplaced pulls, reserved codes, stray bytes.
                        for (int k = $urandom_range(1, 4); k > 0; k--)
                            push_item(pjsu_pkg::op_t'($urandom_range(1, 3)), 8'($urandom),
                                      22'($urandom));
                    end
                endcase
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d chunks with %0d junk segments: %0d transactions accepted,",
                 chunks, junk_segments, accepted);
        $display("%0d output bytes checked, %0d mismatches.", checked, errors);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("packed_junk_stream_unpacker_core verification clean");
        else
            $display("packed_junk_stream_unpacker_core verification failed");
        $finish;
    end

endmodule
